[design/bta_pkg.sv]
`default_nettype none

package bta_pkg;

    // Input mode codes
    localparam logic [1:0] ACT_DEC = 2'd0;
    localparam logic [1:0] ACT_PAD = 2'd1;
    localparam logic [1:0] ACT_HEX = 2'd2;

    // Operand size codes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // Fixed field widths
    localparam int NUM_W  = 64;
    localparam int PAD_W  = 5;
    localparam int CHAR_W = 7;

    // Padded width limit for operand sizes up to 32 bits
    localparam logic [PAD_W-1:0] PAD_LIMIT_SMALL = 5'd10;

    // Double dabble adjust threshold and offset
    localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [3:0] DIGIT_ADJ_ADD = 4'd3;

    // ASCII bases
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_SEVEN = 7'h37;
    localparam logic [3:0]        NIB_MAX_DEC = 4'd9;

    // Control for one digit cell
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift_up;
    } bta_cell_ctl_t;

    // Map one nibble to its upper-case ASCII digit
    function automatic logic [CHAR_W-1:0] nib_to_ascii(input logic [3:0] nib);
        logic [CHAR_W-1:0] ext;
        ext = {3'b000, nib};
        if (nib <= NIB_MAX_DEC) begin
            nib_to_ascii = ext + ASCII_ZERO;
        end else begin
            nib_to_ascii = ext + ASCII_SEVEN;
        end
    endfunction

endpackage

`default_nettype wire

[design/bta_bcd_cell.sv]
`default_nettype none

module bta_bcd_cell
    import bta_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire bta_cell_ctl_t ctl,
    input  wire logic          carry_in,
    input  wire logic [3:0]    digit_in,
    output logic               carry_out,
    output logic [3:0]         digit_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Add three to digits of five and up before the doubling
    assign adj       = (digit_reg >= DIGIT_ADJ_MIN) ? (digit_reg + DIGIT_ADJ_ADD) : digit_reg;
    assign carry_out = adj[3];
    assign digit_out = digit_reg;

    // Clear, double with carry from below, or take the lower neighbor's digit
    always_comb begin
        digit_next = digit_reg;
        if (ctl.clear) begin
            digit_next = 4'd0;
        end else if (ctl.dabble) begin
            digit_next = {adj[2:0], carry_in};
        end else if (ctl.shift_up) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= 4'd0;
        end else begin
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

[design/binary_to_ascii_decimal_hex_core.sv]
`default_nettype none

// Channel   Ports                                              Direction
// s_        s_valid s_ready s_action s_size_code s_number_in   in
//           s_min_digits
// m_        m_valid m_ready m_ascii_char m_last_char           out
//
// Decimal: take the transaction, then VALUE_BITS steps of shift-and-adjust in the
// row of MAX_DEC_DIGITS digit cells, then shift the row up one digit per cycle
// while m_ready does not stall; leading zeros past the padded width are not sent.
// Hex: one character per cycle while m_ready does not stall, 2/4/8/16 characters.
// Reset (aresetn low, synchronous) clears the digit row, counters and output valid.
// A stalled m_ready holds the output register and freezes the character scan.
module binary_to_ascii_decimal_hex_core
    import bta_pkg::*;
#(
    parameter int MAX_DEC_DIGITS = 20,
    parameter int VALUE_BITS     = 64
)(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_action,
    input  wire logic [1:0]        s_size_code,
    input  wire logic [NUM_W-1:0]  s_number_in,
    input  wire logic [PAD_W-1:0]  s_min_digits,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CHAR_W-1:0]      m_ascii_char,
    output logic                   m_last_char
);

    localparam int POS_W  = $clog2(MAX_DEC_DIGITS);
    localparam int STEP_W = $clog2(VALUE_BITS);
    localparam logic [NUM_W-1:0] VAL_MASK   = {NUM_W{1'b1}} >> (NUM_W - VALUE_BITS);
    localparam logic [PAD_W-1:0] PAD_LIMIT_WIDE = PAD_W'(MAX_DEC_DIGITS);
    localparam logic [PAD_W-1:0] PAD_ONE    = 5'd1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_DEC  = 2'd2;
    localparam logic [1:0] ST_HEX  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [NUM_W-1:0]  shifter_reg, shifter_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [PAD_W-1:0]  pad_reg, pad_next;
    logic              ovf_reg, ovf_next;
    logic              started_reg, started_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg, m_char_next;
    logic              m_last_reg, m_last_next;

    logic [NUM_W-1:0]  masked;
    logic [NUM_W-1:0]  hex_aligned;
    logic [POS_W-1:0]  hex_last_pos;
    logic [PAD_W-1:0]  pad_limit;
    logic [PAD_W-1:0]  pad_clamped;
    logic              out_free;
    logic              accept;
    logic              emit_dec;
    bta_cell_ctl_t     cell_ctl;

    logic [MAX_DEC_DIGITS-1:0] carry_w;
    logic [3:0]                digit_w [MAX_DEC_DIGITS];

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_ascii_char = m_char_reg;
    assign m_last_char  = m_last_reg;

    // Mask the operand to its size and left-align it for hex output
    always_comb begin
        case (s_size_code)
            SIZE_8: begin
                masked       = {56'd0, s_number_in[7:0]};
                hex_aligned  = {s_number_in[7:0], 56'd0};
                hex_last_pos = POS_W'(1);
            end
            SIZE_16: begin
                masked       = {48'd0, s_number_in[15:0]};
                hex_aligned  = {s_number_in[15:0], 48'd0};
                hex_last_pos = POS_W'(3);
            end
            SIZE_32: begin
                masked       = {32'd0, s_number_in[31:0]};
                hex_aligned  = {s_number_in[31:0], 32'd0};
                hex_last_pos = POS_W'(7);
            end
            default: begin
                masked       = s_number_in;
                hex_aligned  = s_number_in & VAL_MASK;
                hex_last_pos = POS_W'(15);
            end
        endcase
        masked      = masked & VAL_MASK;
    end

    // Clamp the padded width to the size limit
    always_comb begin
        pad_limit   = (s_size_code == SIZE_64) ? PAD_LIMIT_WIDE : PAD_LIMIT_SMALL;
        if (pad_limit > PAD_LIMIT_WIDE) begin
            pad_limit = PAD_LIMIT_WIDE;
        end
        pad_clamped = (s_min_digits > pad_limit) ? pad_limit : s_min_digits;
    end

    // Decide whether the top cell's digit goes out this cycle
    assign emit_dec = started_reg || ovf_reg || (digit_w[MAX_DEC_DIGITS-1] != 4'd0)
                      || (PAD_W'(pos_reg) < pad_reg);

    // Sequence: take, convert, scan digits or nibbles
    always_comb begin
        state_next   = state_reg;
        shifter_next = shifter_reg;
        step_next    = step_reg;
        pos_next     = pos_reg;
        pad_next     = pad_reg;
        ovf_next     = ovf_reg;
        started_next = started_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        cell_ctl     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_HEX) begin
                        shifter_next = hex_aligned;
                        pos_next     = hex_last_pos;
                        state_next   = ST_HEX;
                    end else if ((s_action == ACT_DEC) ||
                                 ((s_action == ACT_PAD) && (pad_clamped != '0))) begin
                        shifter_next  = masked;
                        step_next     = STEP_W'(VALUE_BITS - 1);
                        pad_next      = (s_action == ACT_PAD) ? pad_clamped : PAD_ONE;
                        ovf_next      = 1'b0;
                        cell_ctl.clear = 1'b1;
                        state_next    = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                cell_ctl.dabble = 1'b1;
                shifter_next    = shifter_reg << 1;
                ovf_next        = ovf_reg || carry_w[MAX_DEC_DIGITS-1];
                if (step_reg == '0) begin
                    pos_next     = POS_W'(MAX_DEC_DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = ST_DEC;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DEC: begin
                if (out_free) begin
                    cell_ctl.shift_up = 1'b1;
                    if (emit_dec) begin
                        started_next = 1'b1;
                        m_valid_next = 1'b1;
                        m_char_next  = nib_to_ascii(digit_w[MAX_DEC_DIGITS-1]);
                        m_last_next  = (pos_reg == '0);
                    end
                    if (pos_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            ST_HEX: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = nib_to_ascii(shifter_reg[NUM_W-1 -: 4]);
                    m_last_next  = (pos_reg == '0);
                    shifter_next = shifter_reg << 4;
                    if (pos_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Row of BCD digit cells, least significant at index zero
    genvar gi;
    generate
        for (gi = 0; gi < MAX_DEC_DIGITS; gi++) begin : g_cell
            logic       c_in;
            logic [3:0] d_in;
            if (gi == 0) begin : g_first
                assign c_in = shifter_reg[VALUE_BITS-1];
                assign d_in = 4'd0;
            end else begin : g_rest
                assign c_in = carry_w[gi-1];
                assign d_in = digit_w[gi-1];
            end
            bta_bcd_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (cell_ctl),
                .carry_in  (c_in),
                .digit_in  (d_in),
                .carry_out (carry_w[gi]),
                .digit_out (digit_w[gi])
            );
        end
    endgenerate

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            pos_reg     <= '0;
            ovf_reg     <= 1'b0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            pos_reg     <= pos_next;
            ovf_reg     <= ovf_next;
            started_reg <= started_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        shifter_reg <= shifter_next;
        pad_reg     <= pad_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

endmodule

`default_nettype wire
